FILE: rtl/md5h_pkg.sv
package md5h_pkg;

	localparam int WORD_W    = 32;
	localparam int BLK_WORDS = 16;
	localparam int WADDR_W   = $clog2(BLK_WORDS);
	localparam int CNT_W     = 64;

	// word slots that carry the bit length in the last block
	localparam logic [WADDR_W-1:0] LEN_LO_WORD = WADDR_W'(14);
	localparam logic [WADDR_W-1:0] LEN_HI_WORD = WADDR_W'(15);
	localparam logic [WADDR_W-1:0] LAST_WORD   = WADDR_W'(15);
	localparam logic [WADDR_W-1:0] LAST_PAD_WORD = WADDR_W'(13);

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [WORD_W-1:0] IV [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [WORD_W-1:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word used by a round
	function automatic logic [WADDR_W-1:0] msg_word(input logic [5:0] r);
		logic [3:0] n;
		logic [3:0] g;
		n = r[3:0];
		unique case (r[5:4])
			2'd0: g = n;
			2'd1: g = n * 4'd5 + 4'd1;
			2'd2: g = n * 4'd3 + 4'd5;
			2'd3: g = n * 4'd7;
		endcase
		return g;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] r);
		return ROT_TAB[{r[5:4], r[1:0]}];
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE, ST_PAD, ST_ZERO, ST_LEN0, ST_LEN1, ST_START, ST_WAIT, ST_DONE
	} top_state_t;

	typedef enum logic [1:0] {
		CS_IDLE, CS_PREF, CS_ROUND, CS_ADD
	} core_state_t;

	typedef enum logic [1:0] {
		RET_IDLE, RET_PAD, RET_ZERO, RET_OUT
	} ret_t;

	typedef struct packed {
		logic start;
		logic clear;
	} core_ctl_t;

	typedef struct packed {
		logic done;
	} core_sts_t;

endpackage

FILE: rtl/md5h_if.sv
interface md5h_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
	modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
	modport mon    (input valid, ready, data_byte, byte_valid, end_of_message);
endinterface

interface md5h_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_low;
	logic [63:0] digest_high;

	modport source (output valid, digest_low, digest_high, input ready);
	modport sink   (input valid, digest_low, digest_high, output ready);
	modport mon    (input valid, ready, digest_low, digest_high);
endinterface

FILE: rtl/md5h_ram.sv
module md5h_ram
	import md5h_pkg::*;
#(
	parameter int WIDTH = WORD_W,
	parameter int DEPTH = BLK_WORDS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/md5h_core.sv
module md5h_core
	import md5h_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  core_ctl_t          ctl,
	output core_sts_t          sts,
	output logic [WADDR_W-1:0] raddr,
	input  logic [WORD_W-1:0]  rdata,
	output logic [63:0]        digest_low,
	output logic [63:0]        digest_high
);

	core_state_t state_q, state_d;

	logic [WORD_W-1:0] cv_q [4];
	logic [WORD_W-1:0] a_q, b_q, c_q, d_q;
	logic [WORD_W-1:0] ak_q;
	logic [5:0]        i_q;
	logic [5:0]        i_nx;
	logic [WORD_W-1:0] f;
	logic [WORD_W-1:0] sum;
	logic [63:0]       dbl;
	logic [WORD_W-1:0] b_new;

	assign i_nx = i_q + 6'd1;

	always_comb begin
		unique case (i_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
		endcase
		// ak_q already holds a + K for this round
		sum   = ak_q + f + rdata;
		dbl   = {sum, sum} << rot_amt(i_q);
		b_new = b_q + dbl[63:32];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE:  if (ctl.start) state_d = CS_PREF;
			CS_PREF:  state_d = CS_ROUND;
			CS_ROUND: if (i_q == 6'd63) state_d = CS_ADD;
			CS_ADD:   state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		sts.done = 1'b0;
		raddr    = msg_word(i_nx);
		unique case (state_q)
			CS_IDLE:  raddr = msg_word(6'd0);
			CS_PREF:  raddr = msg_word(6'd0);
			CS_ROUND: raddr = msg_word(i_nx);
			CS_ADD:   sts.done = 1'b1;
			default:  sts.done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			cv_q    <= IV;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				CS_IDLE: begin
					if (ctl.clear) cv_q <= IV;
				end
				CS_PREF: begin
					i_q <= '0;
				end
				CS_ROUND: begin
					i_q <= i_nx;
				end
				CS_ADD: begin
					cv_q[0] <= cv_q[0] + a_q;
					cv_q[1] <= cv_q[1] + b_q;
					cv_q[2] <= cv_q[2] + c_q;
					cv_q[3] <= cv_q[3] + d_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_PREF) begin
			a_q  <= cv_q[0];
			b_q  <= cv_q[1];
			c_q  <= cv_q[2];
			d_q  <= cv_q[3];
			ak_q <= cv_q[0] + K_TAB[0];
		end else if (state_q == CS_ROUND) begin
			a_q  <= d_q;
			b_q  <= b_new;
			c_q  <= b_q;
			d_q  <= c_q;
			ak_q <= d_q + K_TAB[i_nx];
		end
	end

	assign digest_low  = {cv_q[1], cv_q[0]};
	assign digest_high = {cv_q[3], cv_q[2]};

endmodule

FILE: rtl/md5_byte_stream_hasher.sv
// MD5 hasher fed one message byte per item.
//
// Channels: msg carries data_byte, byte_valid and end_of_message; dig carries
// the 16-byte digest as digest_low (bytes 0..7) and digest_high (bytes 8..15),
// byte 0 in the low bits. An item moves when valid and ready are both high.
// An item with end_of_message closes the message (its byte, if byte_valid,
// is hashed first); an end item with no byte hashes whatever came before,
// the empty message included. Items with neither flag are dropped.
//
// msg.ready is high only while the sequencer is idle. Every 64th byte stalls
// the input while the round engine runs its 64 rounds, one per cycle, reading
// one message word a cycle from the 16 x 32 block RAM. After the end item come
// the padding writes (up to 16 a block, 18 in all) and one or two compressions,
// and then the digest is loaded into the output register.
//
// Reset clears the byte count, restores the initial chaining words and empties
// the output register. The block RAM needs no clearing. A stalled digest holds
// in the output register; the next message is accepted meanwhile, and only a
// second digest waits for the register to free up.
module md5_byte_stream_hasher
	import md5h_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	md5h_in_if.sink   msg,
	md5h_out_if.source dig
);

	top_state_t state_q, state_d;
	ret_t       ret_q, ret_d;

	logic [CNT_W-1:0]   cnt_q;
	logic [23:0]        asm_q;
	logic [WADDR_W-1:0] wp_q;
	logic [WADDR_W-1:0] lim_q;
	logic               ov_q;
	logic [63:0]        dlow_q, dhigh_q;

	logic               acc;
	logic [1:0]         lane;
	logic [5:0]         pos;
	logic [WADDR_W-1:0] idx;
	logic               big;
	logic [WADDR_W-1:0] lim;
	logic [CNT_W-1:0]   bits;
	logic [WORD_W-1:0]  pad_word;
	logic               out_free;
	logic               load_out;

	logic               we;
	logic [WADDR_W-1:0] waddr;
	logic [WORD_W-1:0]  wdata;
	logic [WADDR_W-1:0] raddr;
	logic [WORD_W-1:0]  rdata;

	core_ctl_t   ctl;
	core_sts_t   sts;
	logic [63:0] cv_low, cv_high;

	assign acc  = msg.valid && msg.ready;
	assign lane = cnt_q[1:0];
	assign pos  = cnt_q[5:0];
	assign idx  = pos[5:2];
	// the 0x80 lands past byte 55: length needs a block of its own
	assign big  = (pos[5:3] == 3'd7);
	assign lim  = big ? LAST_WORD : LAST_PAD_WORD;
	assign bits = {cnt_q[CNT_W-4:0], 3'b000};

	assign out_free = !ov_q || dig.ready;

	// keep the bytes below the pad position, then 0x80, then zeros
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (k < int'(lane)) begin
				pad_word[8*k +: 8] = (k == 3) ? 8'h00 : asm_q[8*k +: 8];
			end else if (k == int'(lane)) begin
				pad_word[8*k +: 8] = PAD_BYTE;
			end else begin
				pad_word[8*k +: 8] = 8'h00;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (msg.byte_valid && pos == 6'd63) begin
						state_d = ST_START;
						ret_d   = msg.end_of_message ? RET_PAD : RET_IDLE;
					end else if (msg.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (idx == lim) begin
					if (big) begin
						state_d = ST_START;
						ret_d   = RET_ZERO;
					end else begin
						state_d = ST_LEN0;
					end
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (wp_q == lim_q) begin
					if (lim_q == LAST_WORD) begin
						state_d = ST_START;
						ret_d   = RET_ZERO;
					end else begin
						state_d = ST_LEN0;
					end
				end
			end
			ST_LEN0: state_d = ST_LEN1;
			ST_LEN1: begin
				state_d = ST_START;
				ret_d   = RET_OUT;
			end
			ST_START: state_d = ST_WAIT;
			ST_WAIT: begin
				if (sts.done) begin
					unique case (ret_q)
						RET_IDLE: state_d = ST_IDLE;
						RET_PAD:  state_d = ST_PAD;
						RET_ZERO: state_d = ST_ZERO;
						RET_OUT:  state_d = ST_DONE;
					endcase
				end
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		msg.ready = 1'b0;
		we        = 1'b0;
		waddr     = wp_q;
		wdata     = '0;
		ctl       = '0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				we        = acc && msg.byte_valid && (lane == 2'd3);
				waddr     = idx;
				wdata     = {msg.data_byte, asm_q};
			end
			ST_PAD: begin
				we    = 1'b1;
				waddr = idx;
				wdata = pad_word;
			end
			ST_ZERO: begin
				we    = 1'b1;
				waddr = wp_q;
			end
			ST_LEN0: begin
				we    = 1'b1;
				waddr = LEN_LO_WORD;
				wdata = bits[31:0];
			end
			ST_LEN1: begin
				we    = 1'b1;
				waddr = LEN_HI_WORD;
				wdata = bits[63:32];
			end
			ST_START: ctl.start = 1'b1;
			ST_WAIT:  ;
			ST_DONE: begin
				load_out  = out_free;
				ctl.clear = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_IDLE;
			cnt_q   <= '0;
			wp_q    <= '0;
			lim_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (acc && msg.byte_valid) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_PAD) begin
				wp_q  <= idx + WADDR_W'(1);
				lim_q <= lim;
			end else if (state_q == ST_ZERO) begin
				wp_q <= wp_q + WADDR_W'(1);
			end else if (state_q == ST_WAIT && sts.done && ret_q == RET_ZERO) begin
				// second padding block: zero words up to the length slots
				wp_q  <= '0;
				lim_q <= LAST_PAD_WORD;
			end
			if (load_out) begin
				cnt_q <= '0;
				ov_q  <= 1'b1;
			end else if (dig.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && msg.byte_valid && lane != 2'd3) begin
			asm_q[{lane, 3'b000} +: 8] <= msg.data_byte;
		end
		if (load_out) begin
			dlow_q  <= cv_low;
			dhigh_q <= cv_high;
		end
	end

	md5h_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BLK_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	md5h_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.raddr       (raddr),
		.rdata       (rdata),
		.digest_low  (cv_low),
		.digest_high (cv_high)
	);

	assign dig.valid       = ov_q;
	assign dig.digest_low  = dlow_q;
	assign dig.digest_high = dhigh_q;

endmodule

FILE: rtl/md5h_chk.sv
module md5h_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        msg_end,
	input logic        dig_valid,
	input logic        dig_ready,
	input logic [63:0] dig_low,
	input logic [63:0] dig_high
);

	// a stalled digest holds
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig_low)
			&& $stable(dig_high))
		else $error("digest dropped or changed while stalled");

	// padding or a compression starts right after an end item, so input stalls
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg_end |=> !msg_ready)
		else $error("input taken right after an end item");

	// a digest is loaded only from the busy sequencer
	a_dig_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid) |-> $past(!msg_ready))
		else $error("digest appeared while input was open");

endmodule

bind md5_byte_stream_hasher md5h_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg.valid),
	.msg_ready (msg.ready),
	.msg_end   (msg.end_of_message),
	.dig_valid (dig.valid),
	.dig_ready (dig.ready),
	.dig_low   (dig.digest_low),
	.dig_high  (dig.digest_high)
);
